[rtl/mnpt_pkg.sv]
// Shared codes and types for the MIDI note pairing tracker.
`timescale 1ns / 1ps

package mnpt_pkg;

    // Input command codes.
    localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
    localparam logic [2:0] CMD_CONTROL  = 3'd2;
    localparam logic [2:0] CMD_PROGRAM  = 3'd3;
    localparam logic [2:0] CMD_FLUSH    = 3'd4;

    // Result kind codes.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_NOTE    = 3'd1;
    localparam logic [2:0] KIND_CONTROL = 3'd2;
    localparam logic [2:0] KIND_PROGRAM = 3'd3;
    localparam logic [2:0] KIND_DONE    = 3'd4;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  number;
        logic [6:0]  value;
        logic [31:0] start_time;
        logic [31:0] duration;
    } t_result;

endpackage

[rtl/mnpt_active_rows.sv]
// Active-note bit rows, one row per channel, with a per-row occupancy flag.
`timescale 1ns / 1ps

module mnpt_active_rows #(
    parameter int ROWS  = 16,
    parameter int WIDTH = 128,
    parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_row,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [ROW_W-1:0] i_wr_row,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [ROWS-1:0]  o_row_any
);

    logic [WIDTH-1:0] r_mem [ROWS];
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_ok;
    logic [ROWS-1:0]  r_any;

    // A row whose flag is clear holds no open note, whatever the array holds.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_any[i_wr_row] <= |i_wr_data;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_any[i_rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;
    assign o_row_any = r_any;

endmodule

[rtl/mnpt_note_store.sv]
// Start time and velocity storage for every table entry.
`timescale 1ns / 1ps

module mnpt_note_store #(
    parameter int ADDR_W    = 11,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output logic [TIME_BITS-1:0] o_rd_start,
    output logic [6:0]           o_rd_velocity,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [TIME_BITS-1:0] i_wr_start,
    input  logic [6:0]           i_wr_velocity
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [TIME_BITS+6:0] r_mem [DEPTH];
    logic [TIME_BITS+6:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_velocity, i_wr_start};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_start    = r_rd[TIME_BITS-1:0];
    assign o_rd_velocity = r_rd[TIME_BITS+6:TIME_BITS];

endmodule

[rtl/midi_note_pairing_tracker.sv]
// Top level of the MIDI note pairing tracker: sequencer, scan unit and output register.
`timescale 1ns / 1ps
//
// The block takes one timed MIDI event per input transfer and returns exactly
// one result transfer for it. Note-on and note-off events open and close
// entries of a channel by pitch table; a closed note comes out with its start
// time, velocity and duration. Control and program changes pass through with
// the event time. A flush step closes the lowest open entry, channel first,
// then pitch, and reports flush complete once nothing is open.
// Input is taken only while the sequencer is idle; o_in_stall is high while
// an item is in work. Control, program and unknown commands, and note events
// outside the table, go straight to emit; other note events pass a table
// read, then a read-modify-write. A flush step finds the channel, reads its
// active row and loads a shift register that walks the row one bit a cycle,
// then closes the note found with the same read and read-modify-write. A
// flush with nothing open goes straight to emit. The sequencer returns to
// idle in the same cycle as the result loads into the output register.
// The result sits in an output register, so the next item is accepted while
// a result still waits; while a stalled result holds, the next one waits in
// the emit state and the input stays stalled. Reset clears the sequencer,
// the output valid flag and the per-channel occupancy flags, which stand in
// for a cleared table, so the block is ready in the first cycle after reset.

module midi_note_pairing_tracker #(
    parameter int NUM_CHANNELS = 16,
    parameter int NUM_PITCHES  = 128,
    parameter int TIME_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_number,
    input  logic [6:0]  i_value,
    input  logic [31:0] i_event_time,
    // Result output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_out_channel,
    output logic [6:0]  o_out_number,
    output logic [6:0]  o_out_value,
    output logic [31:0] o_start_time,
    output logic [31:0] o_duration
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int P_W  = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_ROWRD = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [3:0]             r_chan, n_chan;
    logic [6:0]             r_num, n_num;
    logic [6:0]             r_val, n_val;
    logic [TIME_BITS-1:0]   r_time, n_time;
    logic                   r_close, n_close;
    logic [NUM_PITCHES-1:0] r_scan, n_scan;
    logic [P_W-1:0]         r_pitch, n_pitch;
    mnpt_pkg::t_result      r_res, n_res;
    mnpt_pkg::t_result      r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   in_xfer;
    logic                   in_table;
    logic                   row_rd_en;
    logic [NUM_PITCHES-1:0] row_rd_data;
    logic                   row_wr_en;
    logic [NUM_PITCHES-1:0] row_wr_data;
    logic [NUM_CHANNELS-1:0] row_any;
    logic                   st_rd_en;
    logic                   st_wr_en;
    logic [TIME_BITS-1:0]   st_start;
    logic [6:0]             st_velocity;
    logic [CH_W+P_W-1:0]    entry_addr;
    logic [CH_W-1:0]        first_ch;
    logic                   bit_open;
    logic [TIME_BITS-1:0]   diff;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign in_table   = (32'(i_channel) < NUM_CHANNELS) && (32'(i_number) < NUM_PITCHES);
    assign entry_addr = {r_chan[CH_W-1:0], r_num[P_W-1:0]};
    assign bit_open   = row_rd_data[r_num[P_W-1:0]];
    assign diff       = r_time - st_start;

    // Lowest channel that still has an open note.
    always_comb begin
        first_ch = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (row_any[i]) begin
                first_ch = CH_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        n_num       = r_num;
        n_val       = r_val;
        n_time      = r_time;
        n_close     = r_close;
        n_scan      = r_scan;
        n_pitch     = r_pitch;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        row_rd_en   = 1'b0;
        row_wr_en   = 1'b0;
        row_wr_data = row_rd_data;
        st_rd_en    = 1'b0;
        st_wr_en    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_chan  = i_channel;
                    n_num   = i_number;
                    n_val   = i_value;
                    n_time  = TIME_BITS'(i_event_time);
                    n_close = !((i_command == mnpt_pkg::CMD_NOTE_ON) && (i_value != 7'd0));
                    n_res   = '0;
                    n_state = S_EMIT;
                    case (i_command)
                        mnpt_pkg::CMD_NOTE_ON, mnpt_pkg::CMD_NOTE_OFF: begin
                            if (in_table) begin
                                n_state = S_READ;
                            end
                        end
                        mnpt_pkg::CMD_CONTROL: begin
                            n_res.kind       = mnpt_pkg::KIND_CONTROL;
                            n_res.channel    = i_channel;
                            n_res.number     = i_number;
                            n_res.value      = i_value;
                            n_res.start_time = 32'(TIME_BITS'(i_event_time));
                        end
                        mnpt_pkg::CMD_PROGRAM: begin
                            n_res.kind       = mnpt_pkg::KIND_PROGRAM;
                            n_res.channel    = i_channel;
                            n_res.value      = i_value;
                            n_res.start_time = 32'(TIME_BITS'(i_event_time));
                        end
                        mnpt_pkg::CMD_FLUSH: begin
                            n_state = S_FIND;
                        end
                        default: begin
                            n_res.kind = mnpt_pkg::KIND_NONE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (|row_any) begin
                    n_chan  = 4'(first_ch);
                    n_state = S_ROWRD;
                end else begin
                    n_res.kind = mnpt_pkg::KIND_DONE;
                    n_state    = S_EMIT;
                end
            end
            S_ROWRD: begin
                row_rd_en = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                n_scan  = row_rd_data;
                n_pitch = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // The row is known to hold an open note, so this stops in time.
                if (r_scan[0]) begin
                    n_num   = 7'(r_pitch);
                    n_close = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_scan  = r_scan >> 1;
                    n_pitch = r_pitch + 1'b1;
                end
            end
            S_READ: begin
                row_rd_en = 1'b1;
                st_rd_en  = 1'b1;
                n_state   = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_EMIT;
                if (bit_open) begin
                    n_res.kind       = mnpt_pkg::KIND_NOTE;
                    n_res.channel    = r_chan;
                    n_res.number     = r_num;
                    n_res.value      = st_velocity;
                    n_res.start_time = 32'(st_start);
                    n_res.duration   = r_close ? 32'(diff) : 32'd0;
                end
                if (!r_close) begin
                    st_wr_en                  = 1'b1;
                    row_wr_en                 = 1'b1;
                    row_wr_data[r_num[P_W-1:0]] = 1'b1;
                end else if (bit_open) begin
                    row_wr_en                 = 1'b1;
                    row_wr_data[r_num[P_W-1:0]] = 1'b0;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan  <= n_chan;
        r_num   <= n_num;
        r_val   <= n_val;
        r_time  <= n_time;
        r_close <= n_close;
        r_scan  <= n_scan;
        r_pitch <= n_pitch;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    mnpt_active_rows #(
        .ROWS  (NUM_CHANNELS),
        .WIDTH (NUM_PITCHES),
        .ROW_W (CH_W)
    ) u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (row_rd_en),
        .i_rd_row  (r_chan[CH_W-1:0]),
        .o_rd_data (row_rd_data),
        .i_wr_en   (row_wr_en),
        .i_wr_row  (r_chan[CH_W-1:0]),
        .i_wr_data (row_wr_data),
        .o_row_any (row_any)
    );

    mnpt_note_store #(
        .ADDR_W    (CH_W + P_W),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_en       (st_rd_en),
        .i_rd_addr     (entry_addr),
        .o_rd_start    (st_start),
        .o_rd_velocity (st_velocity),
        .i_wr_en       (st_wr_en),
        .i_wr_addr     (entry_addr),
        .i_wr_start    (r_time),
        .i_wr_velocity (r_val)
    );

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_out_channel = r_out.channel;
    assign o_out_number  = r_out.number;
    assign o_out_value   = r_out.value;
    assign o_start_time  = r_out.start_time;
    assign o_duration    = r_out.duration;

endmodule
